@@ design/laser_scan_point_projection_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Laser scan point projection - assertion macros
// Shared property shapes used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LASER_SCAN_POINT_PROJECTION_UNIT_DEFINES_SVH
`define LASER_SCAN_POINT_PROJECTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lspp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser scan point projection - shared package
// Widths, limits, codes, controller/datapath interface types and the
// beam cosine/sine table builder.
// ----------------------------------------------------------------------------
package lspp_pkg;

    // Field widths
    localparam int RAY_IDX_W   = 10;
    localparam int RANGE_W     = 16;
    localparam int Q15_W       = 16;
    localparam int POS_W       = 23;
    localparam int WORLD_W     = 24;
    localparam int PT_IDX_W    = 10;
    localparam int COUNT_W     = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 23;

    // Scan geometry
    localparam int NUM_RAYS            = 1024;
    localparam int MAX_RANGE_MM        = 30000;
    localparam int MIN_RANGE_MM        = 20;
    localparam int ANGLE_STEP_MICRORAD = 4363;
    localparam int TWO_PI_URAD         = 6283185;
    localparam int HALF_PI_URAD        = 1570796;

    // Keep window: range*100 <= 99*max and range*10 >= 11*min
    localparam int RANGE_KEEP_MAX = (MAX_RANGE_MM * 99) / 100;
    localparam int RANGE_KEEP_MIN = (MIN_RANGE_MM * 11 + 9) / 10;

    // Datapath widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = Q15_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int BEAM_W  = 32;
    localparam int PZ_W    = 34;
    localparam int ACC_W   = 56;
    localparam int Q_FRAC  = 15;
    localparam int W_FRAC  = 30;

    // Trig table
    localparam int TRIG_DEPTH = 1 << RAY_IDX_W;
    localparam int TRIG_W     = 2 * Q15_W;
    typedef logic [TRIG_DEPTH-1:0][TRIG_W-1:0] t_trig_rom;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEVATION_SINE = 3'd0,
        CFG_HEIGHT_SCALE   = 3'd1,
        CFG_SENSOR_HEIGHT  = 3'd2,
        CFG_ROBOT_X        = 3'd3,
        CFG_ROBOT_Y        = 3'd4,
        CFG_HEADING_COSINE = 3'd5,
        CFG_HEADING_SINE   = 3'd6
    } t_cfg_reg;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_BX,
        ST_MUL_RS,
        ST_SAVE_RS,
        ST_MUL_BY,
        ST_MUL_BZ,
        ST_MUL_XC,
        ST_MUL_XS,
        ST_MUL_YC,
        ST_MUL_YS,
        ST_ACC_Y,
        ST_FINISH
    } t_ctrl_state;

    // Datapath step commands
    typedef enum logic [3:0] {
        DP_NONE,
        DP_MUL_BX,
        DP_MUL_RS,
        DP_SAVE_RS,
        DP_MUL_BY,
        DP_MUL_BZ,
        DP_MUL_XC,
        DP_MUL_XS,
        DP_MUL_YC,
        DP_MUL_YS,
        DP_ACC_Y,
        DP_FINISH
    } t_dp_step;

    typedef struct packed {
        logic     capture;
        t_dp_step step;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic keep;
        logic out_free;
    } t_dp_status;

    // Q2.30 product with truncation
    function automatic logic [63:0] m30(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // Round Q2.30 to Q1.15, clamp to [0, 32767]
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (v < 0) ? 64'd0 : 64'(v);
        r   = (mag + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return Q15_W'(r);
    endfunction

    // One table entry {sine, cosine} for a ray index
    function automatic logic [TRIG_W-1:0] trig_entry(input int unsigned idx);
        logic [63:0]               a;
        logic [63:0]               q;
        logic [63:0]               t;
        logic [63:0]               u;
        logic [63:0]               u2;
        logic [63:0]               p;
        logic [63:0]               one;
        logic signed [63:0]        cv;
        logic signed [Q15_W-1:0]   s;
        logic signed [Q15_W-1:0]   c;
        logic signed [Q15_W-1:0]   cb;
        logic signed [Q15_W-1:0]   sb;
        one = 64'd1 << 30;
        a   = (64'(idx) * 64'(ANGLE_STEP_MICRORAD)) % 64'(TWO_PI_URAD);
        q   = a / 64'(HALF_PI_URAD);
        if (q > 64'd3) begin
            q = 64'd3;
        end
        t  = a - q * 64'(HALF_PI_URAD);
        u  = (t << 30) / 64'd1000000;
        u2 = m30(u, u);
        p  = one - m30(u2, one / 64'd110);
        p  = one - m30(u2, p / 64'd72);
        p  = one - m30(u2, p / 64'd42);
        p  = one - m30(u2, p / 64'd20);
        p  = one - m30(u2, p / 64'd6);
        s  = to_q15($signed(m30(u, p)));
        p  = one - m30(u2, one / 64'd132);
        p  = one - m30(u2, p / 64'd90);
        p  = one - m30(u2, p / 64'd56);
        p  = one - m30(u2, p / 64'd30);
        p  = one - m30(u2, p / 64'd12);
        cv = $signed(one) - $signed(m30(u2, p / 64'd2));
        c  = to_q15(cv);
        case (q[1:0])
            2'd0: begin
                cb = c;
                sb = s;
            end
            2'd1: begin
                cb = -s;
                sb = c;
            end
            2'd2: begin
                cb = -c;
                sb = -s;
            end
            default: begin
                cb = s;
                sb = -c;
            end
        endcase
        return {sb, cb};
    endfunction

    function automatic t_trig_rom build_trig_rom();
        t_trig_rom rom;
        for (int i = 0; i < TRIG_DEPTH; i++) begin
            rom[i] = trig_entry(i);
        end
        return rom;
    endfunction

endpackage

@@ design/lspp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser scan point projection - controller
// Sequences one item through the shared multiplier and the finish step.
// ----------------------------------------------------------------------------
module lspp_ctrl import lspp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL_BX;
                end
            end
            // out-of-window rays skip the arithmetic
            ST_MUL_BX:  n_state = i_status.keep ? ST_MUL_RS : ST_FINISH;
            ST_MUL_RS:  n_state = ST_SAVE_RS;
            ST_SAVE_RS: n_state = ST_MUL_BY;
            ST_MUL_BY:  n_state = ST_MUL_BZ;
            ST_MUL_BZ:  n_state = ST_MUL_XC;
            ST_MUL_XC:  n_state = ST_MUL_XS;
            ST_MUL_XS:  n_state = ST_MUL_YC;
            ST_MUL_YC:  n_state = ST_MUL_YS;
            ST_MUL_YS:  n_state = ST_ACC_Y;
            ST_ACC_Y:   n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.step    = DP_NONE;
        o_cmd.finish  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_MUL_BX:  o_cmd.step = DP_MUL_BX;
            ST_MUL_RS:  o_cmd.step = DP_MUL_RS;
            ST_SAVE_RS: o_cmd.step = DP_SAVE_RS;
            ST_MUL_BY:  o_cmd.step = DP_MUL_BY;
            ST_MUL_BZ:  o_cmd.step = DP_MUL_BZ;
            ST_MUL_XC:  o_cmd.step = DP_MUL_XC;
            ST_MUL_XS:  o_cmd.step = DP_MUL_XS;
            ST_MUL_YC:  o_cmd.step = DP_MUL_YC;
            ST_MUL_YS:  o_cmd.step = DP_MUL_YS;
            ST_ACC_Y:   o_cmd.step = DP_ACC_Y;
            ST_FINISH: begin
                o_cmd.step   = DP_FINISH;
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/lspp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser scan point projection - datapath
// Configuration registers, trig table, shared multiplier, accumulators,
// drop tests, point counter and output register.
// ----------------------------------------------------------------------------
module lspp_dpath import lspp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [RAY_IDX_W-1:0]       i_ray_index,
    input  logic [RANGE_W-1:0]         i_range_mm,
    input  logic                       i_end_of_scan,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [WORLD_W-1:0]  o_world_x,
    output logic signed [WORLD_W-1:0]  o_world_y,
    output logic [PT_IDX_W-1:0]        o_point_index
);

    localparam t_trig_rom TRIG_ROM = build_trig_rom();

    localparam logic signed [PZ_W-1:0]  PZ_LIM   = PZ_W'(100 * (1 << Q_FRAC));
    localparam logic signed [ACC_W-1:0] NEAR_LIM = ACC_W'(64'd100 << W_FRAC);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (W_FRAC - 1));
    localparam int SHIFT_W = ACC_W - W_FRAC;
    localparam logic signed [SHIFT_W-1:0] WORLD_MAX = SHIFT_W'((1 << (WORLD_W - 1)) - 1);
    localparam logic signed [SHIFT_W-1:0] WORLD_MIN = -SHIFT_W'(1 << (WORLD_W - 1));
    localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [PT_IDX_W-1:0] PT_MAX    = '1;

    // Configuration registers
    logic signed [Q15_W-1:0] r_elev_sine;
    logic signed [Q15_W-1:0] r_height_scale;
    logic [Q15_W-1:0]        r_sensor_height;
    logic signed [POS_W-1:0] r_robot_x;
    logic signed [POS_W-1:0] r_robot_y;
    logic signed [Q15_W-1:0] r_head_cos;
    logic signed [Q15_W-1:0] r_head_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elev_sine     <= 16'sd32767;
            r_height_scale  <= '0;
            r_sensor_height <= '0;
            r_robot_x       <= '0;
            r_robot_y       <= '0;
            r_head_cos      <= 16'sd32767;
            r_head_sin      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ELEVATION_SINE: r_elev_sine     <= i_cfg_data[Q15_W-1:0];
                CFG_HEIGHT_SCALE:   r_height_scale  <= i_cfg_data[Q15_W-1:0];
                CFG_SENSOR_HEIGHT:  r_sensor_height <= i_cfg_data[Q15_W-1:0];
                CFG_ROBOT_X:        r_robot_x       <= i_cfg_data[POS_W-1:0];
                CFG_ROBOT_Y:        r_robot_y       <= i_cfg_data[POS_W-1:0];
                CFG_HEADING_COSINE: r_head_cos      <= i_cfg_data[Q15_W-1:0];
                CFG_HEADING_SINE:   r_head_sin      <= i_cfg_data[Q15_W-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // Captured item and table read
    logic [RANGE_W-1:0]      r_range;
    logic                    r_eos;
    logic signed [Q15_W-1:0] r_cb;
    logic signed [Q15_W-1:0] r_sb;
    logic                    r_keep;
    logic                    n_keep;

    // Working values
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [BEAM_W-1:0]  r_bx;
    logic signed [BEAM_W-1:0]  r_rs;
    logic signed [BEAM_W-1:0]  r_by;
    logic signed [BEAM_W-1:0]  r_bz;
    logic signed [ACC_W-1:0]   r_acc_x;
    logic signed [ACC_W-1:0]   r_acc_y;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [ACC_W-1:0]   w_prod_ext;
    logic signed [PROD_W-1:0]  w_prod_sh;
    logic signed [PZ_W-1:0]    w_pz;
    logic                      w_pz_low;
    logic                      w_near;
    logic                      w_emit;

    // Operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.step)
            DP_MUL_BX: begin
                w_mul_a = $signed({{(MUL_A_W-RANGE_W){1'b0}}, r_range});
                w_mul_b = {r_cb[Q15_W-1], r_cb};
            end
            DP_MUL_RS: begin
                w_mul_a = $signed({{(MUL_A_W-RANGE_W){1'b0}}, r_range});
                w_mul_b = {r_sb[Q15_W-1], r_sb};
            end
            DP_MUL_BY: begin
                w_mul_a = r_rs;
                w_mul_b = {r_elev_sine[Q15_W-1], r_elev_sine};
            end
            DP_MUL_BZ: begin
                w_mul_a = r_rs;
                w_mul_b = {r_height_scale[Q15_W-1], r_height_scale};
            end
            DP_MUL_XC: begin
                w_mul_a = r_bx;
                w_mul_b = {r_head_cos[Q15_W-1], r_head_cos};
            end
            DP_MUL_XS: begin
                w_mul_a = r_by;
                w_mul_b = {r_head_sin[Q15_W-1], r_head_sin};
            end
            DP_MUL_YC: begin
                w_mul_a = r_bx;
                w_mul_b = {r_head_sin[Q15_W-1], r_head_sin};
            end
            DP_MUL_YS: begin
                w_mul_a = r_by;
                w_mul_b = {r_head_cos[Q15_W-1], r_head_cos};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_prod_sh  = r_prod >>> Q_FRAC;

    // Vertical test: |height*2^15 + bz| <= 100*2^15 drops the point
    assign w_pz = $signed({{(PZ_W-Q15_W-Q_FRAC){1'b0}}, r_sensor_height, {Q_FRAC{1'b0}}})
                + $signed({{(PZ_W-BEAM_W){r_bz[BEAM_W-1]}}, r_bz});
    assign w_pz_low = (w_pz >= -PZ_LIM) && (w_pz <= PZ_LIM);

    // Origin test: both axes strictly inside 100 mm
    assign w_near = (r_acc_x > -NEAR_LIM) && (r_acc_x < NEAR_LIM)
                 && (r_acc_y > -NEAR_LIM) && (r_acc_y < NEAR_LIM);
    assign w_emit = r_keep && !w_near;

    function automatic logic signed [WORLD_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]   sum;
        logic signed [SHIFT_W-1:0] sh;
        sum = v + ROUND_HALF;
        sh  = SHIFT_W'(sum >>> W_FRAC);
        if (sh > WORLD_MAX) begin
            sh = WORLD_MAX;
        end else if (sh < WORLD_MIN) begin
            sh = WORLD_MIN;
        end
        return sh[WORLD_W-1:0];
    endfunction

    // Keep flag
    always_comb begin
        n_keep = r_keep;
        if (i_cmd.capture) begin
            n_keep = (32'(i_ray_index) < NUM_RAYS)
                  && (32'(i_range_mm) <= RANGE_KEEP_MAX)
                  && (32'(i_range_mm) >= RANGE_KEEP_MIN);
        end else if (i_cmd.step == DP_MUL_XS && w_pz_low) begin
            n_keep = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
        end else begin
            r_keep <= n_keep;
        end
    end

    // Capture, multiply and write back
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (i_cmd.capture) begin
            r_range <= i_range_mm;
            r_eos   <= i_end_of_scan;
            r_cb    <= TRIG_ROM[i_ray_index][Q15_W-1:0];
            r_sb    <= TRIG_ROM[i_ray_index][TRIG_W-1:Q15_W];
        end
        case (i_cmd.step)
            DP_MUL_RS:  r_bx <= r_prod[BEAM_W-1:0];
            DP_SAVE_RS: r_rs <= r_prod[BEAM_W-1:0];
            DP_MUL_BZ:  r_by <= w_prod_sh[BEAM_W-1:0];
            DP_MUL_XC: begin
                r_bz    <= w_prod_sh[BEAM_W-1:0];
                r_acc_x <= {{(ACC_W-POS_W-W_FRAC){r_robot_x[POS_W-1]}}, r_robot_x,
                            {W_FRAC{1'b0}}};
                r_acc_y <= {{(ACC_W-POS_W-W_FRAC){r_robot_y[POS_W-1]}}, r_robot_y,
                            {W_FRAC{1'b0}}};
            end
            DP_MUL_XS:  r_acc_x <= r_acc_x + w_prod_ext;
            DP_MUL_YC:  r_acc_x <= r_acc_x - w_prod_ext;
            DP_MUL_YS:  r_acc_y <= r_acc_y + w_prod_ext;
            DP_ACC_Y:   r_acc_y <= r_acc_y + w_prod_ext;
            default: begin
                // hold
            end
        endcase
    end

    // Point counter and output register
    logic [COUNT_W-1:0]         r_count;
    logic                       r_out_valid;
    logic signed [WORLD_W-1:0]  r_world_x;
    logic signed [WORLD_W-1:0]  r_world_y;
    logic [PT_IDX_W-1:0]        r_point_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (w_emit) begin
                    r_out_valid <= 1'b1;
                end
                if (r_eos) begin
                    r_count <= '0;
                end else if (w_emit && r_count != COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_emit) begin
            r_world_x     <= round_sat(r_acc_x);
            r_world_y     <= round_sat(r_acc_y);
            r_point_index <= (r_count > COUNT_W'(PT_MAX)) ? PT_MAX : r_count[PT_IDX_W-1:0];
        end
    end

    assign o_status.keep     = r_keep;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_world_x         = r_world_x;
    assign o_world_y         = r_world_y;
    assign o_point_index     = r_point_index;

endmodule

@@ design/laser_scan_point_projection_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser scan point projection unit
// Turns laser rays (index, range) into world x/y points with a running index.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one ray per item, tdata = {range_mm, ray_index},
//   tlast marks the last ray of a scan. Output stream m_axis: one world point
//   per kept ray, tdata = {point_index, world_y, world_x}. Dropped rays give
//   no output item.
//   Configuration: write i_cfg_index/i_cfg_data with i_cfg_valid while the
//   block is idle; o_cfg_ready is always high.
//   Timing: a ray in range passes through the accept step, ten steps on the
//   single shared 32x17 multiplier and its write-back, and the finish step;
//   a kept point is valid on m_axis in the cycle after the finish step. A ray
//   outside the range window goes from the first multiplier step straight to
//   the finish step. No new ray is accepted until the last one has finished.
//   Stall: the result sits in the output register; the next ray is accepted
//   and computed, and it waits at its finish step until that register frees.
//   Reset (i_rst_n low, synchronous) restores register defaults, clears the
//   point count and empties the output register.
// ----------------------------------------------------------------------------
`include "laser_scan_point_projection_unit_defines.svh"

module laser_scan_point_projection_unit import lspp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // ray input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [9:0] ray_index, [25:10] range_mm
    input  logic                  s_axis_tlast,   // end_of_scan
    // point output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata    // [23:0] world_x, [47:24] world_y,
                                                  // [57:48] point_index
);

    t_dp_cmd                    w_cmd;
    t_dp_status                 w_status;
    logic signed [WORLD_W-1:0]  w_world_x;
    logic signed [WORLD_W-1:0]  w_world_y;
    logic [PT_IDX_W-1:0]        w_point_index;

    // Config writes always taken; user must send them while block is idle, unchecked
    assign o_cfg_ready = 1'b1;

    lspp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lspp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ray_index   (s_axis_tdata[RAY_IDX_W-1:0]),
        .i_range_mm    (s_axis_tdata[RAY_IDX_W+RANGE_W-1:RAY_IDX_W]),
        .i_end_of_scan (s_axis_tlast),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_world_x     (w_world_x),
        .o_world_y     (w_world_y),
        .o_point_index (w_point_index)
    );

    // Pack the point fields, pad to whole bytes
    assign m_axis_tdata = {{(64 - 2 * WORLD_W - PT_IDX_W){1'b0}},
                           w_point_index, w_world_y, w_world_x};

    // Busy right after taking a ray
    `LSPP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ray accepted while previous still in work")

    // A new point only appears out of the finish step
    `LSPP_ASSERT_NOW(a_point_from_finish, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_cmd.finish), "output valid raised outside finish step")

    // No ray is taken while the datapath is sequencing
    `LSPP_ASSERT_NOW(a_no_accept_in_work, i_clk, i_rst_n, w_cmd.step != DP_NONE, !s_axis_tready, "input ready while datapath busy")

endmodule
